### sv/ilist_pkg.sv
// Shared constants and types for the indexed insert/remove list.
package ilist_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the request and response beats.
    localparam int KIND_BITS   = 3;
    localparam int POS_BITS    = 4;
    localparam int ITEM_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    localparam logic [KIND_BITS-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                ins;
        logic                rem;
        logic [IDX_BITS-1:0] pos;
        t_word               item;
    } t_cell_cmd;

endpackage

### sv/ilist_cell.sv
// One list entry: holds its word and takes a neighbour's on a shift.
module ilist_cell (
    input  logic                          i_clk,
    input  ilist_pkg::t_cell_cmd          i_cmd,
    input  logic [ilist_pkg::IDX_BITS-1:0] i_idx,
    input  ilist_pkg::t_word              i_left,
    input  ilist_pkg::t_word              i_right,
    output ilist_pkg::t_word              o_word
);

    ilist_pkg::t_word r_word;
    ilist_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (i_idx == i_cmd.pos) begin
                n_word = i_cmd.item;
            end else if (i_idx > i_cmd.pos) begin
                n_word = i_left;
            end
        end else if (i_cmd.rem) begin
            if (i_idx >= i_cmd.pos) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### sv/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list: request decode, cell chain, response register.
//
//   beat       direction  handshake                  payload
//   request    in         i_in_valid / o_in_stall    i_kind, i_position, i_item_value
//   response   out        o_out_valid / i_out_stall  o_read_value, o_status, o_entry_count
//
// One request per cycle unless stalled; its response appears in the cycle after acceptance.
// Insert and remove move every later entry in the cell chain in that same cycle.
// Reset clears the count and the response valid; entries are not cleared.
// A stalled response holds the request side only while the output register is full.
module indexed_insert_remove_list (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ilist_pkg::KIND_BITS-1:0]    i_kind,
    input  logic [ilist_pkg::POS_BITS-1:0]     i_position,
    input  logic [ilist_pkg::ITEM_BITS-1:0]    i_item_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ilist_pkg::ITEM_BITS-1:0]    o_read_value,
    output logic [ilist_pkg::STATUS_BITS-1:0]  o_status,
    output logic [ilist_pkg::COUNT_BITS-1:0]   o_entry_count
);

    localparam logic [ilist_pkg::CNT_BITS-1:0] CAP_CNT =
        ilist_pkg::CNT_BITS'(ilist_pkg::CAPACITY);

    logic [ilist_pkg::CNT_BITS-1:0]    r_count;
    logic [ilist_pkg::CNT_BITS-1:0]    n_count;
    logic                              r_out_valid;
    logic [ilist_pkg::ITEM_BITS-1:0]   r_read_value;
    logic [ilist_pkg::ITEM_BITS-1:0]   n_read_value;
    logic [ilist_pkg::STATUS_BITS-1:0] r_status;
    logic [ilist_pkg::STATUS_BITS-1:0] n_status;

    logic                              w_accept;
    logic                              w_full;
    logic [ilist_pkg::CMP_BITS-1:0]    w_pos;
    logic [ilist_pkg::CMP_BITS-1:0]    w_cnt;
    ilist_pkg::t_word                  w_item;
    ilist_pkg::t_cell_cmd              w_cmd;
    ilist_pkg::t_word                  w_words [ilist_pkg::CAPACITY];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_full     = (r_count == CAP_CNT);
    assign w_pos      = ilist_pkg::CMP_BITS'(i_position);
    assign w_cnt      = ilist_pkg::CMP_BITS'(r_count);
    assign w_item     = ilist_pkg::WORD_BITS'(i_item_value);

    always_comb begin
        n_count      = r_count;
        n_status     = ilist_pkg::ST_OK;
        n_read_value = '0;
        w_cmd.ins    = 1'b0;
        w_cmd.rem    = 1'b0;
        w_cmd.pos    = ilist_pkg::IDX_BITS'(i_position);
        w_cmd.item   = w_item;
        unique case (i_kind)
            ilist_pkg::KIND_PUSH: begin
                if (w_full) begin
                    n_status = ilist_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    w_cmd.pos = ilist_pkg::IDX_BITS'(r_count);
                    n_count   = r_count + 1'b1;
                end
            end
            ilist_pkg::KIND_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            ilist_pkg::KIND_INSERT: begin
                if (w_full) begin
                    n_status = ilist_pkg::ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilist_pkg::KIND_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    w_cmd.rem = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            ilist_pkg::KIND_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = ilist_pkg::ST_RANGE;
                end else begin
                    n_read_value = ilist_pkg::ITEM_BITS'(
                        w_words[ilist_pkg::IDX_BITS'(i_position)]);
                end
            end
            default: begin
                // unused kinds: no change
            end
        endcase
        if (!w_accept) begin
            w_cmd.ins = 1'b0;
            w_cmd.rem = 1'b0;
        end
    end

    for (genvar g = 0; g < ilist_pkg::CAPACITY; g++) begin : g_cell
        ilist_pkg::t_word w_left;
        ilist_pkg::t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = w_item;
        end else begin : g_mid_l
            assign w_left = w_words[g-1];
        end
        if (g == ilist_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_words[g];
        end else begin : g_mid_r
            assign w_right = w_words[g+1];
        end
        ilist_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (ilist_pkg::IDX_BITS'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_words[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = ilist_pkg::COUNT_BITS'(r_count);

endmodule

### sv/ilist_chk.sv
// Port-level checks for the indexed insert/remove list, bound to the top level.
module ilist_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [ilist_pkg::ITEM_BITS-1:0]    o_read_value,
    input logic [ilist_pkg::STATUS_BITS-1:0]  o_status,
    input logic [ilist_pkg::COUNT_BITS-1:0]   o_entry_count
);

    // a held response beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("response beat changed while stalled");

    // no new request taken while the response register is full and held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !(i_in_valid && !o_in_stall))
        else $error("request taken over a held response");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= ilist_pkg::COUNT_BITS'(ilist_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ilist_pkg::ST_OK |-> o_read_value == '0)
        else $error("failed request returned data");

    // full status only when the list is at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ilist_pkg::ST_FULL
            |-> o_entry_count == ilist_pkg::COUNT_BITS'(ilist_pkg::CAPACITY))
        else $error("full status below capacity");

endmodule

bind indexed_insert_remove_list ilist_chk u_ilist_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_value  (o_read_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
